FILE: rtl/mvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform
// Field widths, payload structs, the data word that moves between cells, and
// the identity matrix that the configuration registers take at reset.
// ----------------------------------------------------------------------------
package mvt_pkg;

	localparam int unsigned NUM_LANES = 4;
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned FRAC_W    = 16;
	localparam int unsigned PROD_W    = 2 * DATA_W;
	// Four products of up to 2^62 in magnitude need two extra bits.
	localparam int unsigned ACC_W     = PROD_W + 2;
	localparam int unsigned RND_W     = ACC_W - FRAC_W;
	localparam int unsigned NUM_REGS  = 8;
	localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);
	localparam int unsigned CFG_W     = 2 * DATA_W;

	typedef logic signed [DATA_W-1:0] fix_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [RND_W-1:0]  rnd_t;
	typedef logic [CFG_W-1:0]         cfg_word_t;
	typedef logic [REG_IDX_W-1:0]     reg_idx_t;

	typedef struct packed {
		fix_t vec_x;
		fix_t vec_y;
		fix_t vec_z;
		fix_t vec_w;
	} vec_in_t;

	typedef struct packed {
		fix_t out_x;
		fix_t out_y;
		fix_t out_z;
		fix_t out_w;
		logic saturated;
	} vec_out_t;

	// Element 0 of vec is the component that the next cell consumes.
	typedef struct packed {
		fix_t [NUM_LANES-1:0] vec;
		acc_t [NUM_LANES-1:0] acc;
	} cell_data_t;

	localparam acc_t ROUND_HALF = acc_t'(1) <<< (FRAC_W - 1);

	localparam cfg_word_t REG_RESET [NUM_REGS] = '{
		64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
		64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
		64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000,
		64'h0000_0000_0000_0000, 64'h0001_0000_0000_0000
	};

endpackage
`default_nettype wire

FILE: rtl/mvt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_cell: one column cell of the transform chain
// Multiplies the leading vector component by the four entries of its matrix
// column, adds the products to the running row sums, and hands the sums and
// the rotated vector to the next cell. Two pipeline stages with flow control.
// ----------------------------------------------------------------------------
module mvt_cell import mvt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fix_t [NUM_LANES-1:0]  col,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  cell_data_t            up_data,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output cell_data_t            dn_data
);

	logic                 valid_s1;
	logic                 valid_s2;
	logic                 en_s1;
	logic                 en_s2;
	fix_t                 vec_head;
	prod_t [NUM_LANES-1:0] prod_c;
	prod_t [NUM_LANES-1:0] prod_s1;
	cell_data_t           data_s1;
	cell_data_t           data_s2;

	assign en_s2    = !valid_s2 || dn_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign up_ready = en_s1;

	assign vec_head = $signed(up_data.vec[0]);

	always_comb begin
		for (int r = 0; r < NUM_LANES; r++) begin
			prod_c[r] = $signed(col[r]) * vec_head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= up_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && up_valid) begin
			prod_s1 <= prod_c;
			data_s1 <= up_data;
		end
		if (en_s2 && valid_s1) begin
			for (int r = 0; r < NUM_LANES; r++) begin
				data_s2.acc[r] <= $signed(data_s1.acc[r])
					+ $signed({{(ACC_W-PROD_W){prod_s1[r][PROD_W-1]}}, prod_s1[r]});
			end
			// Rotate so that the next cell finds its component in element 0.
			data_s2.vec <= {data_s1.vec[0], data_s1.vec[NUM_LANES-1:1]};
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

endmodule
`default_nettype wire

FILE: rtl/mvt_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mvt_round: rounding, saturation and result register
// Rounds each row sum to nearest at the Q16.16 point with ties upward, clips
// it to the signed 32-bit range and holds the result item until it is taken.
// ----------------------------------------------------------------------------
module mvt_round import mvt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  acc_t [NUM_LANES-1:0]  acc,
	output logic                  res_valid,
	input  logic                  res_ready,
	output vec_out_t              res
);

	logic                  valid_s1;
	logic                  valid_q;
	logic                  en_s1;
	logic                  en_q;
	rnd_t [NUM_LANES-1:0]  rnd_s1;
	acc_t                  biased [NUM_LANES];
	fix_t                  comp   [NUM_LANES];
	logic [NUM_LANES-1:0]  clip;
	logic [RND_W-DATA_W:0] top    [NUM_LANES];
	vec_out_t              res_d;
	vec_out_t              res_q;

	assign en_q     = !valid_q || res_ready;
	assign en_s1    = !valid_s1 || en_q;
	assign up_ready = en_s1;

	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			biased[i] = $signed(acc[i]) + ROUND_HALF;
		end
	end

	// A component fits when the bits from the sign of the 32-bit word upward agree.
	always_comb begin
		for (int i = 0; i < NUM_LANES; i++) begin
			top[i]  = rnd_s1[i][RND_W-1:DATA_W-1];
			clip[i] = !((&top[i]) || !(|top[i]));
			if (!clip[i]) begin
				comp[i] = rnd_s1[i][DATA_W-1:0];
			end else if (rnd_s1[i][RND_W-1]) begin
				comp[i] = {1'b1, {(DATA_W-1){1'b0}}};
			end else begin
				comp[i] = {1'b0, {(DATA_W-1){1'b1}}};
			end
		end
		res_d.out_x     = comp[0];
		res_d.out_y     = comp[1];
		res_d.out_z     = comp[2];
		res_d.out_w     = comp[3];
		res_d.saturated = |clip;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= up_valid;
			end
			if (en_q) begin
				valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && up_valid) begin
			for (int i = 0; i < NUM_LANES; i++) begin
				rnd_s1[i] <= biased[i][ACC_W-1:FRAC_W];
			end
		end
		if (en_q && valid_s1) begin
			res_q <= res_d;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

FILE: rtl/matrix_vector_transform_4x4.sv
`default_nettype none
// Four column cells of two stages each, then a rounding stage and the result
// register, all with per-stage flow control. One item per cycle while
// res_ready does not stall the output.
// Reset: the matrix registers return to the identity and the pipeline empties.
// ----------------------------------------------------------------------------
// matrix_vector_transform_4x4: homogeneous 4x4 matrix times 4-vector
// Q16.16 transform of a vector stream by a matrix held in eight 64-bit
// configuration registers, computed by a chain of column cells.
// ----------------------------------------------------------------------------
module matrix_vector_transform_4x4 import mvt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  reg_idx_t  cfg_index,
	input  cfg_word_t cfg_data,
	input  logic      vec_valid,
	output logic      vec_ready,
	input  vec_in_t   vec,
	output logic      res_valid,
	input  logic      res_ready,
	output vec_out_t  res
);

	cfg_word_t mreg_q [NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				mreg_q[i] <= REG_RESET[i];
			end
		end else if (cfg_we) begin
			mreg_q[cfg_index] <= cfg_data;
		end
	end

	logic       link_valid [NUM_LANES+1];
	logic       link_ready [NUM_LANES+1];
	cell_data_t link_data  [NUM_LANES+1];

	assign link_valid[0]      = vec_valid;
	assign vec_ready          = link_ready[0];
	assign link_data[0].vec   = {vec.vec_w, vec.vec_z, vec.vec_y, vec.vec_x};
	assign link_data[0].acc   = '0;

	for (genvar c = 0; c < NUM_LANES; c++) begin : g_cell
		fix_t [NUM_LANES-1:0] col;

		// Row r, column c sits in register 2r + c/2, odd columns in the upper half.
		for (genvar r = 0; r < NUM_LANES; r++) begin : g_entry
			assign col[r] = mreg_q[2*r + c/2][(c%2)*DATA_W +: DATA_W];
		end

		mvt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.col      (col),
			.up_valid (link_valid[c]),
			.up_ready (link_ready[c]),
			.up_data  (link_data[c]),
			.dn_valid (link_valid[c+1]),
			.dn_ready (link_ready[c+1]),
			.dn_data  (link_data[c+1])
		);
	end

	mvt_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (link_valid[NUM_LANES]),
		.up_ready  (link_ready[NUM_LANES]),
		.acc       (link_data[NUM_LANES].acc),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule
`default_nettype wire
